// ----- design/postfix_to_prefix_converter_core_assert.svh -----
// Assertion macros for the postfix-to-prefix converter.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef POSTFIX_TO_PREFIX_CONVERTER_CORE_ASSERT_SVH
`define POSTFIX_TO_PREFIX_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication
`define P2P_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define P2P_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/p2p_pkg.sv -----
// Shared types and constants for the postfix-to-prefix converter.
// No dependencies.
package p2p_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } in_word_t;

  typedef struct packed {
    logic [7:0] prefix_symbol;
    logic [2:0] status;
    logic       last_of_run;
  } out_word_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR   = 3'd1;
  localparam logic [2:0] ST_MISSING    = 3'd2;
  localparam logic [2:0] ST_UNBALANCED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
           c == CH_PCT || c == CH_CARET;
  endfunction

endpackage

// ----- design/postfix_to_prefix_converter_core.sv -----
// Postfix-to-prefix converter, top level.
// Depends on p2p_pkg and postfix_to_prefix_converter_core_assert.svh.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_word): one postfix character per word,
//    with end_of_expression on the final one. Spaces are skipped, letters and
//    digits are operands, + - * / % ^ are binary operators.
//  - Output channel (out_valid/out_stall/out_word): on an end word, either the
//    prefix string one character per word (status ok) or one error word
//    (prefix_symbol 0). last_of_run marks the final word of the expression.
//  - Per input word: an operand or skipped character goes through S_DEC and
//    S_END; an operator also goes through S_FROM, the shift (symbols from the
//    merged segment's start to the end of the store) and S_OPW. The shift moves
//    one symbol a cycle through the single write port of the symbol store.
//  - End: after the last character's work, S_END hands over to S_EMIT;
//    results stream at one word per cycle while out_stall is low; a stall
//    simply holds the output register and pauses the read-out.
//  - The next input word is taken once the last result sits in the output
//    register, even if it is still stalled.
//  - Reset clears counters, held error and the output valid; memories
//    are not cleared (only written entries are ever read).
module postfix_to_prefix_converter_core #(
  parameter int SYMBOLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  p2p_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output p2p_pkg::out_word_t  out_word
);

  import p2p_pkg::*;

  localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;  // store index
  localparam int CW = $clog2(SYMBOLS + 1);                 // length/count

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a character
  localparam logic [2:0] S_DEC  = 3'd1;  // classify, push or start a merge
  localparam logic [2:0] S_FROM = 3'd2;  // merge start read back
  localparam logic [2:0] S_SH   = 3'd3;  // shift one symbol right per cycle
  localparam logic [2:0] S_OPW  = 3'd4;  // write operator in front
  localparam logic [2:0] S_END  = 3'd5;  // end check / error word
  localparam logic [2:0] S_EMIT = 3'd6;  // stream prefix string

  // ---------------- registers ----------------
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic          end_r, end_nxt;
  logic [AW-1:0] from_r, from_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  // ---------------- memories ----------------
  logic [7:0]    sym_mem [SYMBOLS];
  logic [AW-1:0] start_mem [SYMBOLS];
  logic [7:0]    sym_rdata_r;
  logic [AW-1:0] start_rdata_r;

  logic          sym_we;
  logic [AW-1:0] sym_waddr, sym_raddr;
  logic [7:0]    sym_wdata;
  logic          start_we;
  logic [AW-1:0] start_waddr, start_raddr;
  logic [AW-1:0] start_wdata;

  // ---------------- helpers ----------------
  logic [CW-1:0] used_dec, count_dec2;
  logic [AW-1:0] used_idx, used_m1_idx, count_idx, count_m2_idx;
  logic [AW-1:0] j_m1, j_m2, k_p1;
  logic          slot_free;
  logic          store_full;
  logic [2:0]    fin_err;

  assign used_dec     = used_r - 1'b1;
  assign count_dec2   = count_r - CW'(2);
  assign used_idx     = used_r[AW-1:0];
  assign used_m1_idx  = used_dec[AW-1:0];
  assign count_idx    = count_r[AW-1:0];
  assign count_m2_idx = count_dec2[AW-1:0];
  assign j_m1         = j_r - 1'b1;
  assign j_m2         = j_r - 1'b1 - 1'b1;
  assign k_p1         = k_r + 1'b1;
  assign store_full   = (used_r >= CW'(SYMBOLS)) || (count_r >= CW'(SYMBOLS));
  // output register can take a word this cycle
  assign slot_free    = !out_valid_r || !out_stall;
  // status reported at end of expression
  assign fin_err      = (err_r != ST_OK) ? err_r :
                        ((count_r != CW'(1)) ? ST_UNBALANCED : ST_OK);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    sym_nxt       = sym_r;
    end_nxt       = end_r;
    from_nxt      = from_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    sym_we      = 1'b0;
    sym_waddr   = used_idx;
    sym_wdata   = sym_r;
    sym_raddr   = used_m1_idx;
    start_we    = 1'b0;
    start_waddr = count_idx;
    start_wdata = used_idx;
    start_raddr = count_m2_idx;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt   = in_word.symbol;
          end_nxt   = in_word.end_of_expression;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_END;
        if (err_r != ST_OK || sym_r == CH_SPACE) begin
          // ignored
        end else if (is_alnum(sym_r)) begin
          if (store_full) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            sym_we    = 1'b1;
            start_we  = 1'b1;
            used_nxt  = used_r + 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end else if (is_op(sym_r)) begin
          if (count_r < CW'(2)) begin
            err_nxt = ST_MISSING;
          end else if (used_r >= CW'(SYMBOLS)) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            state_nxt = S_FROM;  // start_raddr already at count-2
          end
        end else begin
          err_nxt = ST_BAD_CHAR;
        end
      end
      S_FROM: begin
        from_nxt  = start_rdata_r;
        j_nxt     = used_idx;
        sym_raddr = used_m1_idx;
        state_nxt = S_SH;
      end
      S_SH: begin
        // sym_rdata_r holds store[j-1]
        sym_we    = 1'b1;
        sym_waddr = j_r;
        sym_wdata = sym_rdata_r;
        sym_raddr = j_m2;
        if (j_m1 == from_r) begin
          state_nxt = S_OPW;
        end else begin
          j_nxt = j_m1;
        end
      end
      S_OPW: begin
        sym_we    = 1'b1;
        sym_waddr = from_r;
        sym_wdata = sym_r;
        used_nxt  = used_r + 1'b1;
        count_nxt = count_r - 1'b1;
        state_nxt = S_END;
      end
      S_END: begin
        sym_raddr = '0;
        if (!end_r) begin
          state_nxt = S_IDLE;
        end else if (fin_err != ST_OK) begin
          if (slot_free) begin
            out_valid_nxt              = 1'b1;
            out_word_nxt.prefix_symbol = '0;
            out_word_nxt.status        = fin_err;
            out_word_nxt.last_of_run   = 1'b1;
            used_nxt  = '0;
            count_nxt = '0;
            err_nxt   = ST_OK;
            state_nxt = S_IDLE;
          end
        end else begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // sym_rdata_r holds store[k]; read address held while stalled
        sym_raddr = k_r;
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.prefix_symbol = sym_rdata_r;
          out_word_nxt.status        = ST_OK;
          out_word_nxt.last_of_run   = (k_r == used_m1_idx);
          if (k_r == used_m1_idx) begin
            used_nxt  = '0;
            count_nxt = '0;
            err_nxt   = ST_OK;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_p1;
            sym_raddr = k_p1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      count_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    end_r      <= end_nxt;
    from_r     <= from_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    out_word_r <= out_word_nxt;
  end

  // symbol store: one write, one registered read
  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= sym_wdata;
    end
    sym_rdata_r <= sym_mem[sym_raddr];
  end

  // segment start table
  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[start_waddr] <= start_wdata;
    end
    start_rdata_r <= start_mem[start_raddr];
  end

  // ---------------- assertions ----------------
`include "postfix_to_prefix_converter_core_assert.svh"

  `P2P_ASSERT_IMP(a_count_le_used, 1'b1, count_r <= used_r && used_r <= CW'(SYMBOLS), "count/used out of range")
  `P2P_ASSERT_IMP(a_shift_above_from, state_r == S_SH, j_r > from_r, "shift pointer passed merge start")
  `P2P_ASSERT_IMP(a_err_word_last, out_valid_r && out_word_r.status != ST_OK, out_word_r.last_of_run && out_word_r.prefix_symbol == 8'd0, "error word malformed")
  `P2P_ASSERT_NXT(a_merge_counts, state_r == S_OPW, count_r == $past(count_r) - 1'b1 && used_r == $past(used_r) + 1'b1, "merge count update wrong")

endmodule

// ----- dv/postfix_to_prefix_converter_core_test.sv -----
// Self-checking test of postfix_to_prefix_converter_core: random and directed postfix
// words, a scoreboard that rebuilds each prefix string, random input gaps and output stalls.
// Depends on p2p_pkg and the converter RTL.
module postfix_to_prefix_converter_core_test;
  import p2p_pkg::*;

  localparam int SYM_DEPTH = 64;

  // Rebuilds the prefix string from accepted words and holds the words still due.
  class prefix_scoreboard;
    logic [7:0] store [SYM_DEPTH];
    logic [5:0] starts [SYM_DEPTH];
    int         seg_count;
    int         used_len;
    logic [2:0] held;
    out_word_t  prefix_due [$];
    int         mismatches;

    function new();
      seg_count  = 0;
      used_len   = 0;
      held       = ST_OK;
      mismatches = 0;
    endfunction

    function bit is_operand(logic [7:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
             (c >= CH_LA && c <= CH_LZ);
    endfunction

    function bit is_operator(logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
             c == CH_PCT || c == CH_CARET;
    endfunction

    // Fold one character into the segment store.
    function void fold_char(logic [7:0] c);
      int from;
      if (held != ST_OK || c == CH_SPACE) return;
      if (is_operand(c)) begin
        if (used_len >= SYM_DEPTH || seg_count >= SYM_DEPTH) begin
          held = ST_OVERFLOW;
          return;
        end
        store[used_len]   = c;
        starts[seg_count] = used_len[5:0];
        seg_count++;
        used_len++;
      end else if (is_operator(c)) begin
        if (seg_count < 2) begin
          held = ST_MISSING;
          return;
        end
        if (used_len >= SYM_DEPTH) begin
          held = ST_OVERFLOW;
          return;
        end
        // top two segments slide right, operator goes in front of the first
        from = starts[seg_count - 2];
        for (int i = used_len; i > from; i--) store[i] = store[i - 1];
        store[from] = c;
        used_len++;
        seg_count--;
      end else begin
        held = ST_BAD_CHAR;
      end
    endfunction

    function void take_char(in_word_t w);
      out_word_t e;
      fold_char(w.symbol);
      if (!w.end_of_expression) return;
      if (held == ST_OK && seg_count != 1) held = ST_UNBALANCED;
      if (held != ST_OK) begin
        e.prefix_symbol = 8'h00;
        e.status        = held;
        e.last_of_run   = 1'b1;
        prefix_due.push_back(e);
      end else begin
        for (int i = 0; i < used_len; i++) begin
          e.prefix_symbol = store[i];
          e.status        = ST_OK;
          e.last_of_run   = (i + 1 == used_len);
          prefix_due.push_back(e);
        end
      end
      seg_count = 0;
      used_len  = 0;
      held      = ST_OK;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_prefix_word(out_word_t got);
      out_word_t want;
      if (prefix_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word sym %02h st %0d last %0b",
                                  got.prefix_symbol, got.status, got.last_of_run));
        return;
      end
      want = prefix_due.pop_front();
      if (got.prefix_symbol !== want.prefix_symbol || got.status !== want.status ||
          got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("got sym %02h st %0d last %0b, want sym %02h st %0d last %0b",
                                  got.prefix_symbol, got.status, got.last_of_run,
                                  want.prefix_symbol, want.status, want.last_of_run));
    endtask

    function int pending();
      return prefix_due.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  prefix_scoreboard sb = new();

  logic [7:0] expr_q [$];
  int         sent     = 0;
  bit         calm     = 1'b0;
  bit         hold_req = 1'b0;

  postfix_to_prefix_converter_core #(.SYMBOLS(SYM_DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Both handshakes are sampled with the values from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_char(in_word);
      if (out_valid && !out_stall) sb.check_prefix_word(out_word);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid                  <= 1'b1;
    in_word.symbol            <= c;
    in_word.end_of_expression <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // end flag rides on the final character of the queue
  task automatic send_expr();
    for (int i = 0; i < expr_q.size(); i++) begin
      send_char(expr_q[i], i == expr_q.size() - 1);
      sent++;
    end
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'(CH_0 + $urandom_range(0, 9));
      1:       return 8'(CH_UA + $urandom_range(0, 25));
      default: return 8'(CH_LA + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 5))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_PCT;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic void load_text(string s);
    expr_q.delete();
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
  endfunction

  // Valid postfix over n operands; greedy puts every operand first for the
  // longest shifts.
  function automatic void build_postfix(int n, bit greedy);
    int depth;
    int left;
    depth = 0;
    left  = n;
    expr_q.delete();
    while (left > 0 || depth > 1) begin
      if (!greedy && $urandom_range(0, 7) == 0) expr_q.push_back(CH_SPACE);
      if (left > 0 && (greedy || depth < 2 || $urandom_range(0, 1))) begin
        expr_q.push_back(rand_operand());
        left--;
        depth++;
      end else begin
        expr_q.push_back(rand_operator());
        depth--;
      end
    end
    if (!greedy && $urandom_range(0, 9) == 0) expr_q.push_back(CH_SPACE);
  endfunction

  function automatic void break_postfix();
    int pos;
    pos = $urandom_range(0, expr_q.size() - 1);
    case ($urandom_range(0, 9))
      7:       expr_q[pos] = 8'($urandom_range(0, 255));
      8:       if (expr_q.size() > 1) expr_q.delete(pos);
      9:       expr_q.insert(pos, $urandom_range(0, 1) ? rand_operator() : rand_operand());
      default: ;
    endcase
  endfunction

  function automatic void build_noise();
    expr_q.delete();
    repeat ($urandom_range(1, 6)) expr_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Receiver: random hold per word, plus one long hold on request.
  initial begin : receiver
    int hold;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = 400;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin : stimulus
    int e;
    e = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operator, field extremes, each error kind but overflow
    load_text("z");        send_expr();
    load_text("09+AZ-*");  send_expr();
    load_text("az/b%c^");  send_expr();
    load_text(" ");        send_expr();   // empty expression
    expr_q = '{8'h00};     send_expr();   // bad character
    expr_q = '{8'hFF, 8'h61}; send_expr(); // error held, rest ignored
    load_text("+");        send_expr();   // missing operand
    load_text("ab");       send_expr();   // two segments left
    load_text("a ");       send_expr();   // end flag on a space
    load_text("a+b");      send_expr();   // missing operand, then ignored

    // random: mostly short well-formed words, some broken, some noise
    while (sent < 220) begin
      e++;
      calm = ($urandom_range(0, 5) == 0);
      if (e == 3) hold_req = 1'b1;
      case (e)
        2: begin
          build_postfix(32, 1'b1);          // 63-symbol result, deepest shifts
        end
        4: begin
          build_postfix(65, 1'b1);
          expr_q = expr_q[0:64];            // 65 operands: push overflow
        end
        6: begin
          build_postfix(64, 1'b1);
          expr_q = expr_q[0:64];            // 64 operands then a merge: overflow
        end
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            build_noise();
          end else begin
            build_postfix($urandom_range(1, 6), 1'b0);
            break_postfix();
          end
        end
      endcase
      send_expr();
    end
    in_valid <= 1'b0;
    // let the scoreboard take the final accepted word first
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/p2p_pkg.sv
design/postfix_to_prefix_converter_core.sv
dv/postfix_to_prefix_converter_core_test.sv
